/* design/bppf_pkg.sv */
// ----------------------------------------------------------------------------
// bppf_pkg: shared types and constants for the power-path mode controller
// mode codes, led codes, register indexes and beat payload structs
// ----------------------------------------------------------------------------
package bppf_pkg;

    localparam int MODE_W     = 3;
    localparam int LED_W      = 3;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE    = 3'd0,
        MODE_SILENT  = 3'd1,
        MODE_FAULT   = 3'd2,
        MODE_OUTPUT  = 3'd3,
        MODE_CHARGE  = 3'd4,
        MODE_CHG_TMO = 3'd5
    } mode_t;

    typedef enum logic [LED_W-1:0] {
        LED_OFF          = 3'd0,
        LED_RED_FAST     = 3'd1,
        LED_GREEN_FADE   = 3'd2,
        LED_ORANGE_BLINK = 3'd3,
        LED_GREEN_BLINK  = 3'd4
    } led_t;

    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_TMO = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHG_TMO  = 1'b1;

    localparam logic [CFG_DATA_W-1:0] IDLE_TMO_RST = 24'd60000;
    localparam logic [CFG_DATA_W-1:0] CHG_TMO_RST  = 24'd14400000;

    typedef struct packed {
        logic charger_present;
        logic polarity_good;
        logic button_on;
        logic bus_activity;
    } tick_flags_t;

    typedef struct packed {
        mode_t mode_code;
        logic  discharge_enable;
        logic  charge_enable;
        led_t  led_pattern;
        logic  shutdown_request;
        logic  fault_status;
    } result_t;

endpackage

/* design/bppf_tick_if.sv */
// ----------------------------------------------------------------------------
// bppf_tick_if: tick channel
// valid/ready channel carrying the four per-tick status flags
// ----------------------------------------------------------------------------
interface bppf_tick_if;
    logic valid;
    logic ready;
    logic charger_present;
    logic polarity_good;
    logic button_on;
    logic bus_activity;

    modport source (
        output valid, charger_present, polarity_good, button_on, bus_activity,
        input  ready
    );
    modport sink (
        input  valid, charger_present, polarity_good, button_on, bus_activity,
        output ready
    );
endinterface

/* design/bppf_result_if.sv */
// ----------------------------------------------------------------------------
// bppf_result_if: result channel
// valid/ready channel carrying mode, switch enables, led code and status
// ----------------------------------------------------------------------------
interface bppf_result_if;
    logic       valid;
    logic       ready;
    logic [2:0] mode_code;
    logic       discharge_enable;
    logic       charge_enable;
    logic [2:0] led_pattern;
    logic       shutdown_request;
    logic       fault_status;

    modport source (
        output valid, mode_code, discharge_enable, charge_enable, led_pattern,
               shutdown_request, fault_status,
        input  ready
    );
    modport sink (
        input  valid, mode_code, discharge_enable, charge_enable, led_pattern,
               shutdown_request, fault_status,
        output ready
    );
endinterface

/* design/bppf_cfg_regs.sv */
// ----------------------------------------------------------------------------
// bppf_cfg_regs: timeout registers
// holds the idle and charge timeout values written through the config port
// ----------------------------------------------------------------------------
module bppf_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [bppf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bppf_pkg::CFG_DATA_W-1:0]    cfg_data,
    output logic [bppf_pkg::CFG_DATA_W-1:0]    idle_tmo,
    output logic [bppf_pkg::CFG_DATA_W-1:0]    chg_tmo
);
    import bppf_pkg::*;

    logic [CFG_DATA_W-1:0] idle_tmo_reg;
    logic [CFG_DATA_W-1:0] chg_tmo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idle_tmo_reg <= IDLE_TMO_RST;
            chg_tmo_reg  <= CHG_TMO_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_IDLE_TMO: idle_tmo_reg <= cfg_data;
                CFG_CHG_TMO:  chg_tmo_reg  <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign idle_tmo = idle_tmo_reg;
    assign chg_tmo  = chg_tmo_reg;

endmodule

/* design/bppf_next.sv */
// ----------------------------------------------------------------------------
// bppf_next: per-tick transition logic
// next mode, counter and fault latch, plus the decoded result beat
// ----------------------------------------------------------------------------
module bppf_next #(
    parameter int COUNT_BITS = 24
) (
    input  bppf_pkg::mode_t                    mode,
    input  logic [COUNT_BITS-1:0]              count,
    input  logic                               fault,
    input  bppf_pkg::tick_flags_t              flags,
    input  logic [bppf_pkg::CFG_DATA_W-1:0]    idle_tmo,
    input  logic [bppf_pkg::CFG_DATA_W-1:0]    chg_tmo,
    output bppf_pkg::mode_t                    mode_next,
    output logic [COUNT_BITS-1:0]              count_next,
    output logic                               fault_next,
    output bppf_pkg::result_t                  res
);
    import bppf_pkg::*;

    localparam int CMP_W = (COUNT_BITS > CFG_DATA_W) ? COUNT_BITS : CFG_DATA_W;

    logic [COUNT_BITS-1:0] bumped;
    logic [COUNT_BITS-1:0] idle_cnt;
    logic                  idle_hit;
    logic                  chg_hit;
    logic                  shut;

    // saturating increment, bus traffic restarts the idle count
    assign bumped   = (&count) ? count : count + COUNT_BITS'(1);
    assign idle_cnt = flags.bus_activity ? '0 : bumped;
    assign idle_hit = (CMP_W'(idle_cnt) == CMP_W'(idle_tmo));
    assign chg_hit  = (CMP_W'(bumped) == CMP_W'(chg_tmo));

    always_comb
    begin
        mode_next  = mode;
        count_next = count;
        fault_next = fault;
        shut       = 1'b0;
        case (mode)
            MODE_IDLE:
            begin
                count_next = idle_cnt;
                if (!flags.polarity_good)
                begin
                    mode_next  = MODE_SILENT;
                    fault_next = 1'b1;
                end
                else if (flags.button_on)
                    mode_next = MODE_OUTPUT;
                else if (flags.charger_present)
                begin
                    mode_next  = MODE_CHARGE;
                    count_next = '0;
                end
                else if (idle_hit)
                begin
                    shut       = 1'b1;
                    count_next = '0;
                end
            end
            MODE_SILENT:
            begin
                if (flags.button_on)
                    mode_next = MODE_FAULT;
            end
            MODE_FAULT, MODE_OUTPUT:
            begin
                if (!flags.button_on)
                begin
                    mode_next  = MODE_IDLE;
                    count_next = '0;
                end
            end
            MODE_CHARGE:
            begin
                count_next = bumped;
                if (flags.button_on)
                    mode_next = MODE_OUTPUT;
                else if (!flags.charger_present)
                begin
                    mode_next  = MODE_IDLE;
                    count_next = '0;
                end
                else if (chg_hit)
                    mode_next = MODE_CHG_TMO;
            end
            MODE_CHG_TMO:
            begin
                if (flags.button_on)
                    mode_next = MODE_OUTPUT;
                else if (!flags.charger_present)
                begin
                    mode_next  = MODE_IDLE;
                    count_next = '0;
                end
            end
            default: ;
        endcase
    end

    // outputs follow the mode the tick ends in
    always_comb
    begin
        res.mode_code        = mode_next;
        res.discharge_enable = 1'b0;
        res.charge_enable    = 1'b0;
        res.led_pattern      = LED_OFF;
        res.shutdown_request = shut;
        res.fault_status     = fault_next;
        case (mode_next)
            MODE_FAULT:   res.led_pattern = LED_RED_FAST;
            MODE_OUTPUT:
            begin
                res.led_pattern      = LED_GREEN_FADE;
                res.discharge_enable = 1'b1;
                res.charge_enable    = 1'b1;
            end
            MODE_CHARGE:
            begin
                res.led_pattern   = LED_ORANGE_BLINK;
                res.charge_enable = 1'b1;
            end
            MODE_CHG_TMO: res.led_pattern = LED_GREEN_BLINK;
            default:      ;
        endcase
    end

endmodule

/* design/battery_power_path_fsm.sv */
// ----------------------------------------------------------------------------
// battery_power_path_fsm: battery power-path mode controller
// one status tick in, one result beat out: mode, switch enables, led code,
// shutdown pulse and latched fault
// ----------------------------------------------------------------------------
//   channel   dir   handshake        payload
//   tick      in    valid / ready    charger_present, polarity_good,
//                                    button_on, bus_activity
//   result    out   valid / ready    mode_code, discharge_enable,
//                                    charge_enable, led_pattern,
//                                    shutdown_request, fault_status
//   cfg       in    cfg_we           cfg_index, cfg_data (write only)
//
// an accepted tick beat sits in the input register; the transition logic
// loads the result register from it when that is empty or being drained;
// a new tick can be accepted every cycle, one beat per clock, unless the
// result stalls; mode, counter and fault latch update in the same cycle
// the result loads; a stall on result backs up through both registers;
// tick.ready drops only when both hold a beat and result is not taken
// reset: mode idle, counter zero, fault clear, timeouts 60000 / 14400000
// ----------------------------------------------------------------------------
module battery_power_path_fsm #(
    parameter int COUNT_BITS = 24
) (
    input  logic                               clk,
    input  logic                               rst_n,
    bppf_tick_if.sink                          tick,
    bppf_result_if.source                      result,
    input  logic                               cfg_we,
    input  logic [bppf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bppf_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import bppf_pkg::*;

    // timeout registers
    logic [CFG_DATA_W-1:0] idle_tmo;
    logic [CFG_DATA_W-1:0] chg_tmo;

    // input stage
    logic        in_valid_reg;
    tick_flags_t in_flags_reg;
    logic        tick_ready;
    logic        advance;

    // controller state
    mode_t                 mode_reg;
    mode_t                 mode_next;
    logic [COUNT_BITS-1:0] count_reg;
    logic [COUNT_BITS-1:0] count_next;
    logic                  fault_reg;
    logic                  fault_next;

    // result stage
    logic    out_valid_reg;
    result_t out_reg;
    result_t res_next;

    bppf_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .idle_tmo  (idle_tmo),
        .chg_tmo   (chg_tmo)
    );

    // pipeline moves whenever the result register is empty or being drained
    assign advance    = !out_valid_reg || result.ready;
    assign tick_ready = !in_valid_reg || advance;
    assign tick.ready = tick_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (tick_ready)
            in_valid_reg <= tick.valid;
    end

    // flag payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (tick_ready && tick.valid)
        begin
            in_flags_reg.charger_present <= tick.charger_present;
            in_flags_reg.polarity_good   <= tick.polarity_good;
            in_flags_reg.button_on       <= tick.button_on;
            in_flags_reg.bus_activity    <= tick.bus_activity;
        end
    end

    bppf_next #(
        .COUNT_BITS (COUNT_BITS)
    ) u_next (
        .mode       (mode_reg),
        .count      (count_reg),
        .fault      (fault_reg),
        .flags      (in_flags_reg),
        .idle_tmo   (idle_tmo),
        .chg_tmo    (chg_tmo),
        .mode_next  (mode_next),
        .count_next (count_next),
        .fault_next (fault_next),
        .res        (res_next)
    );

    // state commits together with the result beat it produced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_IDLE;
            count_reg     <= '0;
            fault_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
            if (in_valid_reg)
            begin
                mode_reg  <= mode_next;
                count_reg <= count_next;
                fault_reg <= fault_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg)
            out_reg <= res_next;
    end

    assign result.valid            = out_valid_reg;
    assign result.mode_code        = out_reg.mode_code;
    assign result.discharge_enable = out_reg.discharge_enable;
    assign result.charge_enable    = out_reg.charge_enable;
    assign result.led_pattern      = out_reg.led_pattern;
    assign result.shutdown_request = out_reg.shutdown_request;
    assign result.fault_status     = out_reg.fault_status;

`ifndef SYNTHESIS
    // fault latch only clears on reset
    a_fault_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(fault_reg))
        else $error("fault latch cleared without reset");

    // silent fault and fault modes are only reachable with the fault latched
    a_fault_modes: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_SILENT || mode_reg == MODE_FAULT) |-> fault_reg)
        else $error("fault mode without latched fault");

    // shutdown pulse only leaves the block while idle
    a_shut_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.shutdown_request) |->
            (out_reg.mode_code == MODE_IDLE))
        else $error("shutdown request outside idle");

    // discharge switch never closes without the charge switch
    a_switch_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.discharge_enable) |-> out_reg.charge_enable)
        else $error("discharge enabled without charge enable");

    // an empty result register never blocks the tick channel
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> tick_ready)
        else $error("tick stalled with empty result register");
`endif

endmodule

/* dv/battery_power_path_fsm_checker.sv */
// ----------------------------------------------------------------------------
// battery_power_path_fsm_checker: result scoreboard for the power-path fsm
// watches tick, result and register writes, keeps its own copy of the mode,
// tick counter and fault latch, and compares every result beat in order
// ----------------------------------------------------------------------------
module battery_power_path_fsm_checker
    import bppf_pkg::*;
#(
    parameter int COUNT_BITS = 24
) (
    input  logic                  clk,
    input  logic                  rst_n,
    bppf_tick_if                  tick,
    bppf_result_if                result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    fail_count,
    output int                    pending,
    output int                    checked,
    output int                    shutdowns,
    output int                    chg_timeouts
);

    mode_t                   cur_mode;
    logic [COUNT_BITS-1:0]   tick_cnt;
    logic                    fault_latched;
    logic [CFG_DATA_W-1:0]   idle_limit;
    logic [CFG_DATA_W-1:0]   chg_limit;
    result_t                 expected_beats[$];
    int                      errors;
    int                      backlog;
    int                      n_checked;
    int                      n_shutdowns;
    int                      n_chg_tmo;

    assign fail_count   = errors;
    assign pending      = backlog;
    assign checked      = n_checked;
    assign shutdowns    = n_shutdowns;
    assign chg_timeouts = n_chg_tmo;

    // saturating counter bump
    task automatic bump_count();
        if (tick_cnt != '1)
            tick_cnt = tick_cnt + COUNT_BITS'(1);
    endtask

    function automatic bit count_hits(input logic [CFG_DATA_W-1:0] limit);
        return longint'(tick_cnt) == longint'(limit);
    endfunction

    // one tick of the mode machine, returns the beat it should produce
    task automatic advance_tick(input tick_flags_t f, output result_t r);
        logic shut;
        shut = 1'b0;
        case (cur_mode)
            MODE_IDLE:
            begin
                bump_count();
                if (f.bus_activity)
                    tick_cnt = '0;
                if (!f.polarity_good)
                begin
                    cur_mode      = MODE_SILENT;
                    fault_latched = 1'b1;
                end
                else if (f.button_on)
                    cur_mode = MODE_OUTPUT;
                else if (f.charger_present)
                begin
                    cur_mode = MODE_CHARGE;
                    tick_cnt = '0;
                end
                else if (count_hits(idle_limit))
                begin
                    shut     = 1'b1;
                    tick_cnt = '0;
                    n_shutdowns++;
                end
            end
            MODE_SILENT:
            begin
                if (f.button_on)
                    cur_mode = MODE_FAULT;
            end
            MODE_FAULT, MODE_OUTPUT:
            begin
                if (!f.button_on)
                begin
                    cur_mode = MODE_IDLE;
                    tick_cnt = '0;
                end
            end
            MODE_CHARGE:
            begin
                bump_count();
                if (f.button_on)
                    cur_mode = MODE_OUTPUT;
                else if (!f.charger_present)
                begin
                    cur_mode = MODE_IDLE;
                    tick_cnt = '0;
                end
                else if (count_hits(chg_limit))
                begin
                    cur_mode = MODE_CHG_TMO;
                    n_chg_tmo++;
                end
            end
            MODE_CHG_TMO:
            begin
                if (f.button_on)
                    cur_mode = MODE_OUTPUT;
                else if (!f.charger_present)
                begin
                    cur_mode = MODE_IDLE;
                    tick_cnt = '0;
                end
            end
            default:
            begin
            end
        endcase

        r.mode_code        = cur_mode;
        r.discharge_enable = (cur_mode == MODE_OUTPUT);
        r.charge_enable    = (cur_mode == MODE_OUTPUT) || (cur_mode == MODE_CHARGE);
        r.shutdown_request = shut;
        r.fault_status     = fault_latched;
        case (cur_mode)
            MODE_FAULT:   r.led_pattern = LED_RED_FAST;
            MODE_OUTPUT:  r.led_pattern = LED_GREEN_FADE;
            MODE_CHARGE:  r.led_pattern = LED_ORANGE_BLINK;
            MODE_CHG_TMO: r.led_pattern = LED_GREEN_BLINK;
            default:      r.led_pattern = LED_OFF;
        endcase
    endtask

    task automatic check_field(input string name, input logic [2:0] want,
                               input logic [2:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        tick_flags_t flags;
        result_t     want;
        if (!rst_n)
        begin
            cur_mode      = MODE_IDLE;
            tick_cnt      = '0;
            fault_latched = 1'b0;
            idle_limit    = IDLE_TMO_RST;
            chg_limit     = CHG_TMO_RST;
            expected_beats.delete();
            backlog <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_IDLE_TMO: idle_limit = cfg_data;
                    CFG_CHG_TMO:  chg_limit  = cfg_data;
                    default:
                    begin
                    end
                endcase
            end

            // compare before pushing so a beat can never match its own tick
            if (result.valid && result.ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("result beat with no expected beat waiting");
                    errors++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    check_field("mode_code", want.mode_code, result.mode_code);
                    check_field("discharge_enable", 3'(want.discharge_enable),
                                3'(result.discharge_enable));
                    check_field("charge_enable", 3'(want.charge_enable),
                                3'(result.charge_enable));
                    check_field("led_pattern", want.led_pattern, result.led_pattern);
                    check_field("shutdown_request", 3'(want.shutdown_request),
                                3'(result.shutdown_request));
                    check_field("fault_status", 3'(want.fault_status),
                                3'(result.fault_status));
                    n_checked++;
                end
            end

            if (tick.valid && tick.ready)
            begin
                flags = {tick.charger_present, tick.polarity_good,
                         tick.button_on, tick.bus_activity};
                advance_tick(flags, want);
                expected_beats.push_back(want);
            end

            backlog <= expected_beats.size();
        end
    end

endmodule

/* dv/battery_power_path_fsm_tb.sv */
// ----------------------------------------------------------------------------
// battery_power_path_fsm_tb: regression bench for the power-path mode fsm
// directed ticks reach every mode and all transitions but chg_tmo to output,
// then mixed random scenes (idle runs, charge runs, output sessions, faults,
// noise) under several timeout settings, bursty ticks, a stalling result sink
// ----------------------------------------------------------------------------
module battery_power_path_fsm_tb;
    import bppf_pkg::*;

    localparam int COUNT_BITS   = 24;
    localparam int CYCLE_LIMIT  = 250000;
    localparam int RANDOM_ITEMS = 185;   // per register setting
    localparam int NUM_SETTINGS = 7;
    localparam int SCENE_CAP    = 60;    // longest idle or charge run

    // receiver stall styles
    typedef enum int {
        RX_OPEN,      // always ready
        RX_COIN,      // ready half the time
        RX_COMB,      // ready unless rx_phase mod 4 is 3
        RX_SPARSE     // ready with probability one in four
    } rx_style_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    bppf_tick_if   tick ();
    bppf_result_if result ();

    int fail_count;
    int pending;
    int checked;
    int shutdowns;
    int chg_timeouts;

    // sender and receiver bookkeeping
    int        n_sent;
    int        n_settings;
    int        burst_left;
    int        idle_cfg;
    int        chg_cfg;
    int        hold_reqs;
    int        hold_done;
    int        hold_left;
    int        rx_left;
    int        rx_phase;
    rx_style_t rx_style;
    int        cycles;

    battery_power_path_fsm #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .tick      (tick),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    battery_power_path_fsm_checker #(
        .COUNT_BITS (COUNT_BITS)
    ) u_chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .tick         (tick),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked),
        .shutdowns    (shutdowns),
        .chg_timeouts (chg_timeouts)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog: a hung handshake or a lost beat ends up here
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("watchdog: no clean finish within %0d cycles, %0d beats outstanding",
                     CYCLE_LIMIT, pending);
            $display("Regression FAIL");
            $finish;
        end
    end

    // result sink: rotates through stall styles, and on request holds ready
    // low for a long stretch so the pipe fills and tick.ready drops
    always @(posedge clk)
    begin
        if (!rst_n)
            result.ready <= 1'b0;
        else
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                result.ready <= 1'b0;
            end
            else if (hold_done != hold_reqs)
            begin
                hold_done++;
                hold_left = $urandom_range(60, 100);
                result.ready <= 1'b0;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_style = rx_style_t'($urandom_range(0, 3));
                    rx_left  = $urandom_range(32, 200);
                end
                rx_left--;
                rx_phase++;
                case (rx_style)
                    RX_OPEN:   result.ready <= 1'b1;
                    RX_COIN:   result.ready <= 1'($urandom_range(0, 1));
                    RX_COMB:   result.ready <= (rx_phase % 4 != 3);
                    default:   result.ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // one tick beat; bursts of random length with random gaps between them,
    // a gap of zero often enough to give long back-to-back stretches
    task automatic drive_tick(input logic chg, input logic pol, input logic btn,
                              input logic bus);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                tick.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        tick.valid           <= 1'b1;
        tick.charger_present <= chg;
        tick.polarity_good   <= pol;
        tick.button_on       <= btn;
        tick.bus_activity    <= bus;
        do
            @(posedge clk);
        while (tick.ready !== 1'b1);
        n_sent++;
    endtask

    // stop sending and wait out every outstanding result beat; the first
    // edge lets the checker count the last accepted tick
    task automatic drain_results();
        tick.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // both timeouts, written back to back while the block is idle
    task automatic write_timeouts(input logic [CFG_DATA_W-1:0] idle_ticks,
                                  input logic [CFG_DATA_W-1:0] chg_ticks);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_IDLE_TMO;
        cfg_data  <= idle_ticks;
        @(posedge clk);
        cfg_index <= CFG_CHG_TMO;
        cfg_data  <= chg_ticks;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        idle_cfg = int'(idle_ticks);
        chg_cfg  = int'(chg_ticks);
        n_settings++;
    endtask

    // mixed scenes: mostly well-formed runs that reach the timeouts, with
    // output sessions, polarity faults and plain noise mixed in
    task automatic play_mixed_ticks(input int n_items);
        int start;
        int pick;
        int len;
        int cap;
        start = n_sent;
        while (n_sent - start < n_items)
        begin
            pick = $urandom_range(0, 9);
            if (pick <= 2)
            begin
                // quiet idle run, occasional bus traffic resets the counter
                cap = (idle_cfg + 3 < SCENE_CAP) ? idle_cfg + 3 : SCENE_CAP;
                len = $urandom_range(1, cap);
                repeat (len)
                    drive_tick(1'b0, 1'b1, 1'b0, ($urandom_range(0, 9) == 0));
            end
            else if (pick <= 4)
            begin
                // charge run, sometimes cut short by the charger going away
                cap = (chg_cfg + 3 < SCENE_CAP) ? chg_cfg + 3 : SCENE_CAP;
                len = $urandom_range(1, cap);
                repeat (len)
                    drive_tick(1'b1, ($urandom_range(0, 7) != 0), 1'b0,
                               1'($urandom_range(0, 1)));
                if ($urandom_range(0, 2) == 0)
                    drive_tick(1'b0, 1'b1, 1'b0, 1'($urandom_range(0, 1)));
                else if ($urandom_range(0, 1) == 0)
                    drive_tick(1'b1, 1'b1, 1'b1, 1'($urandom_range(0, 1)));
            end
            else if (pick == 5)
            begin
                // output session: button held, other flags wander
                len = $urandom_range(1, 8);
                repeat (len)
                    drive_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1,
                               1'($urandom_range(0, 1)));
                drive_tick(1'b0, 1'b1, 1'b0, 1'b0);
            end
            else if (pick == 6 && $urandom_range(0, 1) == 0)
            begin
                // reverse polarity, then the button walk out of fault
                drive_tick(1'($urandom_range(0, 1)), 1'b0, 1'b0, 1'($urandom_range(0, 1)));
                repeat ($urandom_range(0, 3))
                    drive_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0,
                               1'($urandom_range(0, 1)));
                repeat ($urandom_range(1, 3))
                    drive_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b1,
                               1'($urandom_range(0, 1)));
                drive_tick(1'b0, 1'b1, 1'b0, 1'b0);
            end
            else
            begin
                // noise, polarity mostly good
                len = $urandom_range(1, 8);
                repeat (len)
                    drive_tick(1'($urandom_range(0, 1)), ($urandom_range(0, 7) != 0),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial
    begin : stimulus
        logic [CFG_DATA_W-1:0] idle_set [NUM_SETTINGS];
        logic [CFG_DATA_W-1:0] chg_set  [NUM_SETTINGS];

        // every tick and config input known from time zero
        rst_n                = 1'b0;
        cfg_we               = 1'b0;
        cfg_index            = CFG_IDLE_TMO;
        cfg_data             = '0;
        tick.valid           = 1'b0;
        tick.charger_present = 1'b0;
        tick.polarity_good   = 1'b1;
        tick.button_on       = 1'b0;
        tick.bus_activity    = 1'b0;
        idle_cfg             = int'(IDLE_TMO_RST);
        chg_cfg              = int'(CHG_TMO_RST);

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed, reset timeouts, fault still clear
        drive_tick(1'b0, 1'b1, 1'b0, 1'b0);   // quiet idle
        drive_tick(1'b0, 1'b1, 1'b0, 1'b0);
        drive_tick(1'b0, 1'b1, 1'b0, 1'b1);   // bus traffic clears the counter
        drive_tick(1'b1, 1'b1, 1'b0, 1'b0);   // charger seen, start charging
        drive_tick(1'b1, 1'b0, 1'b0, 1'b1);   // charging ignores polarity
        drive_tick(1'b1, 1'b1, 1'b1, 1'b0);   // button wins over charging
        drive_tick(1'b0, 1'b0, 1'b1, 1'b1);   // output holds with button
        drive_tick(1'b0, 1'b1, 1'b0, 1'b0);   // button off, back to idle
        drive_tick(1'b1, 1'b1, 1'b0, 1'b0);   // charge again
        drive_tick(1'b0, 1'b1, 1'b0, 1'b0);   // charger gone, idle
        drive_tick(1'b1, 1'b1, 1'b1, 1'b1);   // button beats charger from idle
        drive_tick(1'b0, 1'b0, 1'b0, 1'b0);   // output drops on button off
        drive_tick(1'b1, 1'b0, 1'b1, 1'b1);   // reverse polarity beats all, latch
        drive_tick(1'b1, 1'b1, 1'b0, 1'b1);   // silent fault waits for button
        drive_tick(1'b0, 1'b1, 1'b1, 1'b0);   // into fault
        drive_tick(1'b1, 1'b1, 1'b1, 1'b1);   // fault holds with button
        drive_tick(1'b0, 1'b1, 1'b0, 1'b0);   // idle again, fault stays latched
        drain_results();

        // directed, short timeouts: shutdown pulse and charge timeout
        write_timeouts(24'd3, 24'd2);
        repeat (3)
            drive_tick(1'b0, 1'b1, 1'b0, 1'b0);   // third quiet tick requests stop
        repeat (3)
            drive_tick(1'b1, 1'b1, 1'b0, 1'b0);   // third charger tick times out
        drive_tick(1'b0, 1'b1, 1'b0, 1'b0);       // charger gone from timeout
        drain_results();

        // settings include zero and full-scale timeouts at both registers
        idle_set[0] = 24'd5;        chg_set[0] = 24'd7;
        idle_set[1] = 24'd1;        chg_set[1] = 24'd1;
        idle_set[2] = 24'd0;        chg_set[2] = 24'd0;
        idle_set[3] = 24'hFFFFFF;   chg_set[3] = 24'hFFFFFF;
        idle_set[4] = 24'd12;       chg_set[4] = 24'd20;
        idle_set[5] = 24'($urandom_range(1, 30));
        chg_set[5]  = 24'($urandom_range(1, 40));
        idle_set[6] = 24'($urandom_range(1, 30));
        chg_set[6]  = 24'($urandom_range(1, 40));

        for (int s = 0; s < NUM_SETTINGS; s++)
        begin
            write_timeouts(idle_set[s], chg_set[s]);
            // long sink hold-off while ticks keep coming
            if (s == 1 || s == 4)
                hold_reqs++;
            play_mixed_ticks(RANDOM_ITEMS);
            drain_results();
        end

        repeat (8) @(posedge clk);

        $display("ticks sent %0d across %0d timeout settings plus reset values",
                 n_sent, n_settings);
        $display("results checked %0d, shutdown pulses %0d, charge timeouts %0d",
                 checked, shutdowns, chg_timeouts);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* battery_power_path_fsm.f */
design/bppf_pkg.sv
design/bppf_tick_if.sv
design/bppf_result_if.sv
design/bppf_cfg_regs.sv
design/bppf_next.sv
design/battery_power_path_fsm.sv
dv/battery_power_path_fsm_checker.sv
dv/battery_power_path_fsm_tb.sv
